FILE: src/hsv2rgb_pkg.sv
// hsv2rgb_pkg: shared constants and word types for the hsv to rgb converter
// no dependencies; imported by every module of the block
package hsv2rgb_pkg;

    localparam int HUE_FRAC_BITS  = 6;
    localparam int UNIT_FRAC_BITS = 10;

    // field widths
    localparam int HUE_W  = 15;
    localparam int UNIT_W = 11;
    localparam int CHAN_W = 8;

    // fixed point scale
    localparam int UNIT      = 1 << UNIT_FRAC_BITS;
    localparam int SECTOR_W  = 60 << HUE_FRAC_BITS;
    localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;
    localparam int NUM_SECT  = 6;

    // internal widths
    localparam int SEC_W  = 3;
    localparam int FRAC_W = $clog2(SECTOR_W + 1);
    localparam int VS_W   = 2 * UNIT_FRAC_BITS + 1;
    localparam int PROD_W = VS_W + FRAC_W;
    localparam int NUM_W  = PROD_W + CHAN_W;

    // register stages of one channel pipe
    localparam int CH_LAT = 3;

    // denominator is 15 * 2^DEN_SHIFT; the power of two is a shift,
    // the factor 15 is a reciprocal multiply on the narrow quotient
    localparam int DEN_SHIFT = 2 * UNIT_FRAC_BITS + HUE_FRAC_BITS + 2;
    localparam int T_W       = 12;
    localparam int RECIP     = 34953;
    localparam int RECIP_SH  = 19;
    localparam int RECIP_W   = 16;

    typedef struct packed {
        logic [HUE_W-1:0]  hue_in;
        logic [UNIT_W-1:0] sat_in;
        logic [UNIT_W-1:0] val_in;
    } t_hsv_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              range_error;
    } t_rgb_word;

    // front stage word: per channel ramp weight g, 0..SECTOR_W
    typedef struct packed {
        logic              valid;
        logic              err;
        logic [VS_W-1:0]   vs;
        logic [UNIT_W-1:0] val;
        logic [FRAC_W-1:0] g_red;
        logic [FRAC_W-1:0] g_green;
        logic [FRAC_W-1:0] g_blue;
    } t_sect_word;

endpackage

FILE: src/hsv_to_rgb_converter.sv
// hsv_to_rgb_converter: top level of the hsv to rgb pixel converter
// depends on hsv2rgb_pkg, hsv2rgb_sector and hsv2rgb_chan
//
// Converts one pixel per clock from hsv (hue in 1/64 degree, saturation and
// value in Q1.10) to 8-bit rgb. A word is taken at every clock edge where
// start is high and busy is low; busy is only high during reset, so a new
// word may be issued in every cycle. The result appears on
// o_result, marked by o_valid for exactly one cycle; the receiver cannot
// stall it, so it must take every result as it comes. The
// pipeline is a front stage (range check, sector decode, v*s multiply), then
// per channel a product stage, a scale and shift stage and a reciprocal
// divide-by-15 stage. Out of range inputs give zero channels with
// range_error set.
module hsv_to_rgb_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hsv2rgb_pkg::t_hsv_word i_item,
    output logic                   o_valid,
    output hsv2rgb_pkg::t_rgb_word o_result
);
    import hsv2rgb_pkg::*;

    t_sect_word        sect;
    logic [CHAN_W-1:0] red, green, blue;
    logic [CH_LAT-1:0] r_vld;
    logic [CH_LAT-1:0] r_err;

    // no back pressure: only reset holds off new words
    assign busy = ~i_rst_n;

    // front stage
    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_sect  (sect)
    );

    // three identical channel pipes, each fed its own ramp weight
    hsv2rgb_chan u_chan_red (
        .i_clk  (i_clk),
        .i_vs   (sect.vs),
        .i_val  (sect.val),
        .i_g    (sect.g_red),
        .o_chan (red)
    );

    hsv2rgb_chan u_chan_green (
        .i_clk  (i_clk),
        .i_vs   (sect.vs),
        .i_val  (sect.val),
        .i_g    (sect.g_green),
        .o_chan (green)
    );

    hsv2rgb_chan u_chan_blue (
        .i_clk  (i_clk),
        .i_vs   (sect.vs),
        .i_val  (sect.val),
        .i_g    (sect.g_blue),
        .o_chan (blue)
    );

    // valid and error flags ride alongside the channel pipes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CH_LAT-2:0], sect.valid};
        end
        r_err <= {r_err[CH_LAT-2:0], sect.err};
    end

    assign o_valid              = r_vld[CH_LAT-1];
    assign o_result.range_error = r_err[CH_LAT-1];
    // out of range forces all channels to zero
    assign o_result.red_out     = r_err[CH_LAT-1] ? '0 : red;
    assign o_result.green_out   = r_err[CH_LAT-1] ? '0 : green;
    assign o_result.blue_out    = r_err[CH_LAT-1] ? '0 : blue;

    // every accepted word comes out after the pipeline latency
    a_accept_to_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(CH_LAT+1) o_valid)
        else $error("accepted word did not produce a result");

    // no result without a word accepted at the right time
    a_result_has_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, CH_LAT+1))
        else $error("result strobe without a matching accepted word");

    // error results carry zero channels
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.range_error) |->
        (o_result.red_out == '0 && o_result.green_out == '0 &&
         o_result.blue_out == '0))
        else $error("range error result with nonzero channel");

endmodule

FILE: src/hsv2rgb_sector.sv
// hsv2rgb_sector: range check, sector decode, ramp and v*s product
// depends on hsv2rgb_pkg
module hsv2rgb_sector (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  hsv2rgb_pkg::t_hsv_word  i_item,
    output hsv2rgb_pkg::t_sect_word o_sect
);
    import hsv2rgb_pkg::*;

    logic [SEC_W-1:0]  sec;
    logic [HUE_W-1:0]  rem;
    logic [FRAC_W-1:0] frac;
    logic [FRAC_W-1:0] full;
    logic [2*UNIT_W-1:0] vs_full;
    t_sect_word        n_sect;
    t_sect_word        r_sect;

    assign full = FRAC_W'(SECTOR_W);

    always_comb begin
        sec = '0;
        for (int k = 1; k < NUM_SECT; k++) begin
            if (i_item.hue_in >= HUE_W'(k * SECTOR_W)) begin
                sec = SEC_W'(k);
            end
        end
        // a full circle lands in the last sector with rem equal to the width
        rem     = i_item.hue_in - HUE_W'(sec * SECTOR_W);
        frac    = sec[0] ? (full - rem[FRAC_W-1:0]) : rem[FRAC_W-1:0];
        vs_full = i_item.sat_in * i_item.val_in;

        n_sect.valid = i_start;
        n_sect.err   = (i_item.hue_in > HUE_W'(HUE_FULL)) ||
                       (i_item.sat_in > UNIT_W'(UNIT)) ||
                       (i_item.val_in > UNIT_W'(UNIT));
        n_sect.vs    = vs_full[VS_W-1:0];
        n_sect.val   = i_item.val_in;

        case (sec)
            3'd0: begin
                n_sect.g_red = full;  n_sect.g_green = frac;  n_sect.g_blue = '0;
            end
            3'd1: begin
                n_sect.g_red = frac;  n_sect.g_green = full;  n_sect.g_blue = '0;
            end
            3'd2: begin
                n_sect.g_red = '0;    n_sect.g_green = full;  n_sect.g_blue = frac;
            end
            3'd3: begin
                n_sect.g_red = '0;    n_sect.g_green = frac;  n_sect.g_blue = full;
            end
            3'd4: begin
                n_sect.g_red = frac;  n_sect.g_green = '0;    n_sect.g_blue = full;
            end
            default: begin
                n_sect.g_red = full;  n_sect.g_green = '0;    n_sect.g_blue = frac;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sect <= '0;
        end else begin
            r_sect <= n_sect;
        end
    end

    assign o_sect = r_sect;

endmodule

FILE: src/hsv2rgb_chan.sv
// hsv2rgb_chan: one color channel, floor(255*num/den) over three stages
// depends on hsv2rgb_pkg
module hsv2rgb_chan (
    input  logic                                i_clk,
    input  logic [hsv2rgb_pkg::VS_W-1:0]        i_vs,
    input  logic [hsv2rgb_pkg::UNIT_W-1:0]      i_val,
    input  logic [hsv2rgb_pkg::FRAC_W-1:0]      i_g,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]      o_chan
);
    import hsv2rgb_pkg::*;

    logic [FRAC_W-1:0]          d;
    logic [PROD_W-1:0]          n_base, r_base;
    logic [PROD_W-1:0]          n_prod, r_prod;
    logic [PROD_W-1:0]          diff;
    logic [NUM_W-1:0]           num;
    logic [T_W-1:0]             n_t, r_t;
    logic [T_W+RECIP_W-1:0]     quot;
    logic [CHAN_W-1:0]          n_q, r_q;

    // stage 1: v*unit*width and v*s*(width - g)
    assign d      = FRAC_W'(SECTOR_W) - i_g;
    assign n_base = (PROD_W'(i_val) << UNIT_FRAC_BITS) * PROD_W'(SECTOR_W);
    assign n_prod = PROD_W'(i_vs) * PROD_W'(d);

    // stage 2: times 255, drop the power of two of the denominator
    assign diff = r_base - r_prod;
    assign num  = {diff, CHAN_W'(0)} - NUM_W'(diff);
    assign n_t  = num[DEN_SHIFT+T_W-1:DEN_SHIFT];

    // stage 3: divide by 15 via reciprocal
    assign quot = (T_W+RECIP_W)'(r_t) * (T_W+RECIP_W)'(RECIP);
    assign n_q  = quot[RECIP_SH+CHAN_W-1:RECIP_SH];

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_prod <= n_prod;
        r_t    <= n_t;
        r_q    <= n_q;
    end

    assign o_chan = r_q;

endmodule
